// ===== hw/rtl/mbe_pkg.sv =====
// Shared types and constants of the Mandelbrot escape-time block.
// Used by mbe_front, mbe_core and the top level under hw/rtl; depends on nothing.
package mbe_pkg;

    localparam int COORD_W  = 16;
    localparam int COORD_FRAC = 12;
    localparam int LIMIT_W  = 16;
    localparam int BAIL_W   = 7;
    localparam int COUNT_W  = 17;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAILOUT    = 1'b1;

    localparam logic [LIMIT_W-1:0] ITER_LIMIT_RESET = 16'd1000;
    localparam logic [BAIL_W-1:0]  BAILOUT_RESET    = 7'd16;

    typedef struct packed {
        logic signed [COORD_W-1:0] plane_x;
        logic signed [COORD_W-1:0] plane_y;
    } t_point;

    typedef struct packed {
        logic [COUNT_W-1:0] escape_count;
        logic               inside_set;
    } t_result;

    typedef struct packed {
        logic [LIMIT_W-1:0] iteration_limit;
        logic [BAIL_W-1:0]  bailout_level;
    } t_cfg;

endpackage

// ===== hw/rtl/mbe_fifo.sv =====
// Small register-based first-in first-out queue of generic width and depth.
// Depends on nothing; used between the front, the iteration engine and the outputs.
module mbe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/mbe_front.sv =====
// Front end: takes plane points, forms the constant c in Q8 fixed point, queues it.
// Depends on mbe_pkg and mbe_fifo.
module mbe_front
    import mbe_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  t_point                    i_point,
    output logic                      o_full,
    input  logic                      i_pop,
    output logic                      o_valid,
    output logic signed [FRAC_BITS+7:0] o_cr,
    output logic signed [FRAC_BITS+7:0] o_ci
);

    localparam int W = FRAC_BITS + 8;
    localparam int SHIFT = FRAC_BITS - COORD_FRAC;
    localparam logic signed [W-1:0] HALF = W'(1) << (FRAC_BITS - 1);

    logic signed [W-1:0] ci, cr;
    logic [2*W-1:0]      q_data;
    logic                q_empty;

    // Widening is exact: sign-extend, then move the binary point.
    assign ci = W'(i_point.plane_x) <<< SHIFT;
    assign cr = (W'(i_point.plane_y) <<< SHIFT) - HALF;

    mbe_fifo #(
        .WIDTH(2 * W),
        .DEPTH(2)
    ) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push),
        .i_data ({cr, ci}),
        .o_full (o_full),
        .i_pop  (i_pop),
        .o_data (q_data),
        .o_empty(q_empty)
    );

    assign o_valid = !q_empty;
    assign o_cr    = q_data[2*W-1:W];
    assign o_ci    = q_data[W-1:0];

endmodule

// ===== hw/rtl/mbe_core.sv =====
// Iteration engine: runs z = z^2 + c for one point at a time, a product step then a sum step per update.
// Depends on mbe_pkg.
module mbe_core
    import mbe_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cfg                        i_cfg,
    input  logic                        i_cmd_valid,
    input  logic signed [FRAC_BITS+7:0] i_cmd_cr,
    input  logic signed [FRAC_BITS+7:0] i_cmd_ci,
    output logic                        o_cmd_pop,
    input  logic                        i_res_full,
    output logic                        o_res_push,
    output t_result                     o_res
);

    localparam int W  = FRAC_BITS + 8;
    localparam int W1 = W + 1;
    localparam int W2 = 2 * W;
    localparam logic signed [W2-1:0] ZMAX_X = {{(W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [W2-1:0] ZMIN_X = {{(W + 1){1'b1}}, {(W - 1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_ADD  = 3'b100
    } t_state;

    function automatic logic signed [W-1:0] sat_w(input logic signed [W2-1:0] v);
        logic signed [W-1:0] r;
        if (v > ZMAX_X) begin
            r = ZMAX_X[W-1:0];
        end else if (v < ZMIN_X) begin
            r = ZMIN_X[W-1:0];
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    t_state              r_state, n_state;
    logic signed [W-1:0] r_cr, r_ci, r_zr, r_zi;
    logic signed [W-1:0] r_sr, r_si, r_cross;
    logic [COUNT_W-1:0]  r_count;

    logic signed [W2-1:0] p_rr, p_ii, p_ri;
    logic signed [W-1:0]  zr_next, zi_next, dbl;
    logic [W:0]           sum_sq, thresh;
    logic [COUNT_W-1:0]   count_next;
    logic                 escaped, limit_hit, load;

    // Products are floored by the arithmetic shift, then clamped to Q8.
    assign p_rr = r_zr * r_zr;
    assign p_ii = r_zi * r_zi;
    assign p_ri = r_zr * r_zi;

    assign zr_next = sat_w(W2'(r_sr) - W2'(r_si) + W2'(r_cr));
    assign dbl     = sat_w(W2'(r_cross) + W2'(r_cross));
    assign zi_next = sat_w(W2'(dbl) + W2'(r_ci));

    assign sum_sq     = {1'b0, r_sr} + {1'b0, r_si};
    assign thresh     = W1'({i_cfg.bailout_level, {FRAC_BITS{1'b0}}});
    assign count_next = r_count + COUNT_W'(1);
    assign escaped    = (sum_sq > thresh);
    assign limit_hit  = (count_next > COUNT_W'(i_cfg.iteration_limit));

    assign load       = (r_state == S_IDLE) && i_cmd_valid && !i_res_full;
    assign o_cmd_pop  = load;
    assign o_res_push = (r_state == S_ADD) && (escaped || limit_hit);

    always_comb begin
        o_res.escape_count = escaped ? count_next : '0;
        o_res.inside_set   = !escaped;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (load) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                n_state = o_res_push ? S_IDLE : S_MUL;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cr    <= i_cmd_cr;
            r_ci    <= i_cmd_ci;
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
        end else if (r_state == S_MUL) begin
            r_sr    <= sat_w(p_rr >>> FRAC_BITS);
            r_si    <= sat_w(p_ii >>> FRAC_BITS);
            r_cross <= sat_w(p_ri >>> FRAC_BITS);
        end else if (r_state == S_ADD) begin
            r_zr    <= zr_next;
            r_zi    <= zi_next;
            r_count <= count_next;
        end
    end

endmodule

// ===== hw/rtl/mandelbrot_escape_time.sv =====
// Top level of the Mandelbrot escape-time block: config registers, front, engine, result queue.
// Depends on mbe_pkg, mbe_fifo, mbe_front and mbe_core.
//
// Channel   Direction  Handshake          Payload
// points    in         push / full       i_point  (plane_x, plane_y, signed Q4.12)
// results   out        pop / empty       o_result (escape_count, inside_set)
// config    in         i_cfg_we          i_cfg_idx, i_cfg_data (no read-back)
//
// The front queues each point beat. The engine takes it in its load step and then runs
// every update as an S_MUL step for the three products followed by an S_ADD step
// for the sums, saturation and the escape test, until the point escapes or passes
// its iteration limit.
// Reset is synchronous and active low; it empties both queues and restores the
// register defaults. Either side may stall: two queued points and two waiting
// results decouple the engine from its neighbors.
module mandelbrot_escape_time
    import mbe_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  t_point                i_point,
    output logic                  full,
    input  logic                  pop,
    output t_result               o_result,
    output logic                  empty,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int W = FRAC_BITS + 8;
    localparam int RES_W = $bits(t_result);

    t_cfg                r_cfg;
    logic                cmd_valid, cmd_pop;
    logic signed [W-1:0] cmd_cr, cmd_ci;
    logic                res_full, res_push;
    t_result             res_data;
    logic [RES_W-1:0]    res_q;

    // Configuration registers. Write only while the block is idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.iteration_limit <= ITER_LIMIT_RESET;
            r_cfg.bailout_level   <= BAILOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ITER_LIMIT: begin
                    r_cfg.iteration_limit <= i_cfg_data[LIMIT_W-1:0];
                end
                CFG_BAILOUT: begin
                    r_cfg.bailout_level <= i_cfg_data[BAIL_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // The front converts each point to c and holds it until the engine is free.
    mbe_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_point(i_point),
        .o_full (full),
        .i_pop  (cmd_pop),
        .o_valid(cmd_valid),
        .o_cr   (cmd_cr),
        .o_ci   (cmd_ci)
    );

    // The engine only starts a point when the result queue has room, so the
    // finishing beat of that point can always be written.
    mbe_core #(
        .FRAC_BITS(FRAC_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd_valid(cmd_valid),
        .i_cmd_cr   (cmd_cr),
        .i_cmd_ci   (cmd_ci),
        .o_cmd_pop  (cmd_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_data)
    );

    mbe_fifo #(
        .WIDTH(RES_W),
        .DEPTH(2)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_data),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (res_q),
        .o_empty(empty)
    );

    assign o_result = res_q;

    // The engine never finishes a point into a full result queue.
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result beat written into a full result queue");

    // A point is only taken from the front while one is waiting there.
    a_cmd_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("engine took a point from an empty front queue");

    // An inside point reports count zero; an escaped point reports a nonzero count.
    a_result_coherent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.inside_set == (o_result.escape_count == '0)))
        else $error("escape count and inside flag disagree");

    // A finished point cannot be followed by another result in the next cycle.
    a_result_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |=> !res_push)
        else $error("two results finished in consecutive cycles");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the Mandelbrot escape-time block.
// Depends on mbe_pkg and the mandelbrot_escape_time top level under hw/rtl.
`timescale 1ns / 100ps

module testbench;
    import mbe_pkg::*;

    localparam int FRAC_BITS = 24;

    // The Q8.FRAC_BITS range that every product and every sum of the update saturates to.
    localparam longint Q_MAX = (longint'(1) << (7 + FRAC_BITS)) - 1;
    localparam longint Q_MIN = -Q_MAX - 1;

    // Cycles allowed after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 8;

    // The random sweep is split into phases, each with its own register setting.
    localparam int SWEEP_PHASES     = 10;
    localparam int POINTS_PER_PHASE = 59;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    t_point                i_point;
    logic                  full;
    logic                  pop;
    t_result               o_result;
    logic                  empty;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Our own copy of the two registers, updated whenever one is written.
    logic [LIMIT_W-1:0] model_limit   = ITER_LIMIT_RESET;
    logic [BAIL_W-1:0]  model_bailout = BAILOUT_RESET;

    // Escape results predicted for accepted points, oldest first.
    t_result expected_escapes[$];

    // When set, neither side inserts idle cycles between beats.
    bit quiet = 1'b0;

    int error_count   = 0;
    int points_sent   = 0;
    int settings_used = 0;
    int inside_seen   = 0;
    int escaped_seen  = 0;

    mandelbrot_escape_time #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .i_point   (i_point),
        .full      (full),
        .pop       (pop),
        .o_result  (o_result),
        .empty     (empty),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety net against a hang, with a wide margin over the slowest
    // correct run.
    initial begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Fixed-point arithmetic of the escape-time iteration.
    // ------------------------------------------------------------------

    function automatic longint q_sat(longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // The exact product fits in 64 bits, and the arithmetic shift rounds
    // toward minus infinity, which is the truncation the block performs.
    function automatic longint q_mul(longint a, longint b);
        return q_sat((a * b) >>> FRAC_BITS);
    endfunction

    // Runs the whole iteration for one point under the current registers.
    function automatic t_result escape_time(t_point pt);
        longint  ci, cr, zr, zi, sr, si, xprod, thresh, count;
        bit      done;
        t_result res;
        ci     = longint'($signed(pt.plane_x)) * (longint'(1) << (FRAC_BITS - COORD_FRAC));
        cr     = longint'($signed(pt.plane_y)) * (longint'(1) << (FRAC_BITS - COORD_FRAC))
                 - (longint'(1) << (FRAC_BITS - 1));
        thresh = longint'(model_bailout) << FRAC_BITS;
        zr     = 0;
        zi     = 0;
        count  = 0;
        done   = 1'b0;
        res    = '0;
        while (!done) begin
            count++;
            xprod = q_mul(zr, zi);
            sr    = q_mul(zr, zr);
            si    = q_mul(zi, zi);
            // The doubled cross product saturates on its own before c is added.
            zr    = q_sat(sr - si + cr);
            zi    = q_sat(q_sat(xprod + xprod) + ci);
            // The escape test looks at the squares of the old z, and it is
            // made before the limit test, so an escape on the update right
            // after the limit still reports its count.
            if (sr + si > thresh) begin
                res.escape_count = count[COUNT_W-1:0];
                res.inside_set   = 1'b0;
                done             = 1'b1;
            end else if (count > longint'(model_limit)) begin
                res.escape_count = '0;
                res.inside_set   = 1'b1;
                done             = 1'b1;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Shared driving tasks. Every task is entered and left at a falling
    // edge, and each one drives a given signal at most once per step.
    // ------------------------------------------------------------------

    function automatic t_point make_point(int x, int y);
        t_point pt;
        pt.plane_x = x[COORD_W-1:0];
        pt.plane_y = y[COORD_W-1:0];
        return pt;
    endfunction

    // Sends one point beat after a random gap and records its prediction at
    // the edge where the block accepts it. Push stays high when the next
    // point follows without a gap.
    task automatic send_point(input t_point pt);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push    <= 1'b1;
        i_point <= pt;
        do @(posedge i_clk); while (full);
        expected_escapes.push_back(escape_time(pt));
        points_sent++;
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every predicted result has come back,
    // then waits out SETTLE_CYCLES so that a stray extra result would be seen.
    task automatic wait_until_drained();
        push <= 1'b0;
        while (expected_escapes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ITER_LIMIT) model_limit = value[LIMIT_W-1:0];
        else if (idx == CFG_BAILOUT) model_bailout = value[BAIL_W-1:0];
        @(negedge i_clk);
    endtask

    // Registers change only while the block is idle, so drain first.
    task automatic configure(input int unsigned limit, input int unsigned bailout);
        wait_until_drained();
        write_register(CFG_ITER_LIMIT, limit);
        write_register(CFG_BAILOUT, bailout);
        settings_used++;
    endtask

    // Points are mostly drawn around the set, where the iteration runs
    // long and the counts spread out, with some on the real axis and some
    // across the whole input range so that every bit toggles.
    function automatic t_point random_point();
        int x, y;
        case ($urandom_range(0, 9))
            0, 1: begin
                x = int'($urandom_range(0, 65535)) - 32768;
                y = int'($urandom_range(0, 65535)) - 32768;
            end
            2: begin
                x = 0;
                y = int'($urandom_range(0, 10240)) - 6144;
            end
            default: begin
                x = int'($urandom_range(0, 12288)) - 6144;
                y = int'($urandom_range(0, 10240)) - 6144;
            end
        endcase
        return make_point(x, y);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random pop stalls and the check of each result beat.
    // ------------------------------------------------------------------

    initial begin : result_sink
        int      gap;
        t_result want;
        pop = 1'b0;
        gap = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (expected_escapes.size() == 0) begin
                    $error("result beat with no point waiting: escape_count %0d inside_set %0d",
                           o_result.escape_count, o_result.inside_set);
                    error_count++;
                end else begin
                    want = expected_escapes.pop_front();
                    if (o_result.escape_count !== want.escape_count) begin
                        $error("escape_count: expected %0d, got %0d",
                               want.escape_count, o_result.escape_count);
                        error_count++;
                    end
                    if (o_result.inside_set !== want.inside_set) begin
                        $error("inside_set: expected %0d, got %0d",
                               want.inside_set, o_result.inside_set);
                        error_count++;
                    end
                    if (want.inside_set) inside_seen++;
                    else escaped_seen++;
                end
                gap = quiet ? 0 : $urandom_range(0, 9);
            end
            @(negedge i_clk);
            if (gap > 0) begin
                pop <= 1'b0;
                gap--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Runs with the register values left by reset, so the defaults are
    // checked without any write. The points cover the extremes of both
    // coordinates and a few famous points of the set: c = -1/2, c = 0,
    // c = -2 on the tip of the real axis, the cusp at c = 1/4 and c = i.
    // The far corners overflow the fixed-point range and saturate.
    task automatic test_reset_defaults();
        send_point(make_point(0, 0));
        send_point(make_point(0, 2048));
        send_point(make_point(0, -6144));
        send_point(make_point(0, 3072));
        send_point(make_point(4096, 2048));
        send_point(make_point(32767, 32767));
        send_point(make_point(-32768, -32768));
        send_point(make_point(-32768, 32767));
        send_point(make_point(32767, -32768));
    endtask

    // A limit of zero ends every point after its first update, where no
    // escape is possible, so every point lands inside. The largest limit
    // lets one point run the full 65536 updates before it is declared inside.
    task automatic test_limit_extremes();
        configure(0, BAILOUT_RESET);
        send_point(make_point(0, 0));
        send_point(make_point(32767, 32767));
        configure(65535, 64);
        send_point(make_point(0, 0));
        send_point(make_point(4096, 4096));
        send_point(make_point(-32768, -32768));
    endtask

    // A bailout of zero escapes as soon as z is nonzero, except at c = 0,
    // where z never moves. The lowest useful level and a high one follow.
    task automatic test_bailout_extremes();
        configure(1, 0);
        send_point(make_point(0, 2048));
        send_point(make_point(0, 0));
        send_point(make_point(100, 2048));
        configure(ITER_LIMIT_RESET, 1);
        send_point(make_point(0, -6144));
        send_point(make_point(2048, 0));
        configure(ITER_LIMIT_RESET, 64);
        send_point(make_point(0, -6144));
        send_point(make_point(-32768, 32767));
    endtask

    // Random points under a series of register settings. The first three
    // phases pin the low extremes, the high bailout and the reset values;
    // the rest draw their limits small so that inside points stay cheap.
    // Every fourth phase runs back to back with no idling on either side,
    // and one phase pauses halfway until every result is back.
    task automatic test_random_sweep();
        int          ph;
        int          n;
        int unsigned limit;
        int unsigned bailout;
        for (ph = 0; ph < SWEEP_PHASES; ph++) begin
            case (ph)
                0: begin
                    limit   = 1;
                    bailout = 1;
                end
                1: begin
                    limit   = 300;
                    bailout = 64;
                end
                2: begin
                    limit   = ITER_LIMIT_RESET;
                    bailout = BAILOUT_RESET;
                end
                default: begin
                    limit   = $urandom_range(2, 300);
                    bailout = $urandom_range(1, 64);
                end
            endcase
            configure(limit, bailout);
            quiet = (ph % 4 == 3);
            for (n = 0; n < POINTS_PER_PHASE; n++) begin
                send_point(random_point());
                if (ph == 5 && n == POINTS_PER_PHASE / 2) wait_until_drained();
            end
            wait_until_drained();
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------

    initial begin : sequencer
        i_rst_n    = 1'b0;
        push       = 1'b0;
        i_point    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_ITER_LIMIT;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_limit_extremes();
        test_bailout_extremes();
        test_random_sweep();
        wait_until_drained();

        $display("Checked %0d points under %0d register settings besides the reset values.",
                 points_sent, settings_used);
        $display("Of these, %0d escaped and %0d were declared inside the set.",
                 escaped_seen, inside_seen);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
